[rtl/core/dngr_pkg.sv]
// ----------------------------------------------------------------------------
// dngr_pkg
// Shared types, constants and the digit glyph table of the glyph renderer.
// ----------------------------------------------------------------------------
package dngr_pkg;

  localparam int BOX_ROWS = 5;
  localparam int BOX_COLS = 11;

  localparam logic [2:0] LAST_ROW = 3'(BOX_ROWS - 1);
  localparam logic [3:0] LAST_COL = 4'(BOX_COLS - 1);

  localparam logic [9:0] MAX_VALUE = 10'd999;

  localparam logic [1:0] REG_INK   = 2'd0;
  localparam logic [1:0] REG_PAPER = 2'd1;
  localparam logic [1:0] REG_CLEAR = 2'd2;

  localparam logic [15:0] INK_RESET   = 16'h0000;
  localparam logic [15:0] PAPER_RESET = 16'hFFFF;
  localparam logic [15:0] CLEAR_RESET = 16'hFFFF;

  localparam logic [1:0] GAP_SUB = 2'd3;

  typedef struct packed {
    logic [9:0] value;
    logic [7:0] origin_row;
    logic [8:0] origin_col;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  pixel_row;
    logic [8:0]  pixel_col;
    logic [15:0] pixel_color;
    logic        last_pixel;
  } out_item_t;

  typedef struct packed {
    logic [2:0][3:0] digits;
    logic [1:0]      ndig;
    logic [7:0]      orow;
    logic [8:0]      ocol;
  } job_t;

  typedef struct packed {
    logic [15:0] ink;
    logic [15:0] paper;
    logic [15:0] clear;
  } cfg_t;

  // rows packed as {row4, row3, row2, row1, row0}, bit c of a row is column c
  function automatic logic [14:0] glyph(input logic [3:0] d);
    logic [14:0] g;
    g = 15'd0;
    unique case (d)
      4'd0:    g = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
      4'd1:    g = {3'd7, 3'd2, 3'd2, 3'd3, 3'd2};
      4'd2:    g = {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
      4'd3:    g = {3'd7, 3'd4, 3'd7, 3'd4, 3'd7};
      4'd4:    g = {3'd4, 3'd4, 3'd7, 3'd5, 3'd5};
      4'd5:    g = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
      4'd6:    g = {3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
      4'd7:    g = {3'd4, 3'd4, 3'd4, 3'd4, 3'd7};
      4'd8:    g = {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
      4'd9:    g = {3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
      default: g = 15'd0;
    endcase
    return g;
  endfunction

endpackage

[rtl/core/dngr_front.sv]
// ----------------------------------------------------------------------------
// dngr_front
// Accepts numbers, clamps value and origin, splits the value into decimal
// digits over two stages and pushes a drawing job into the queue.
// ----------------------------------------------------------------------------
module dngr_front import dngr_pkg::*; #(
  parameter int SCREEN_HEIGHT = 240,
  parameter int SCREEN_WIDTH  = 320
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     q_ready,
  output logic     q_push,
  output job_t     q_job
);

  localparam logic [10:0] ROW_MAX = 11'(SCREEN_HEIGHT - BOX_ROWS);
  localparam logic [10:0] COL_MAX = 11'(SCREEN_WIDTH - BOX_COLS);

  logic       s1_valid;
  logic [9:0] s1_v;
  logic [3:0] s1_hund;
  logic [6:0] s1_q10;
  logic [7:0] s1_orow;
  logic [8:0] s1_ocol;

  logic        take;
  logic [9:0]  v_cl;
  logic [15:0] prod41;
  logic [17:0] prod205;

  logic [6:0] h10;
  logic [6:0] tens7;
  logic [9:0] q10x10;
  logic [9:0] ones10;
  logic [3:0] tens;
  logic [3:0] ones;

  assign in_ready = !s1_valid || q_ready;
  assign take     = in_valid && in_ready;

  // hundreds and value / 10 by reciprocal multiply
  assign v_cl    = (in_item.value > MAX_VALUE) ? MAX_VALUE : in_item.value;
  assign prod41  = 16'(v_cl) * 16'd41;
  assign prod205 = 18'(v_cl) * 18'd205;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (q_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_v    <= v_cl;
      s1_hund <= prod41[15:12];
      s1_q10  <= prod205[17:11];
      s1_orow <= ({3'b000, in_item.origin_row} > ROW_MAX) ? ROW_MAX[7:0]
                                                          : in_item.origin_row;
      s1_ocol <= ({2'b00, in_item.origin_col} > COL_MAX) ? COL_MAX[8:0]
                                                         : in_item.origin_col;
    end
  end

  assign h10    = {3'b000, s1_hund} * 7'd10;
  assign tens7  = s1_q10 - h10;
  assign q10x10 = {3'b000, s1_q10} * 10'd10;
  assign ones10 = s1_v - q10x10;
  assign tens   = tens7[3:0];
  assign ones   = ones10[3:0];

  always_comb begin
    q_job      = '0;
    q_job.orow = s1_orow;
    q_job.ocol = s1_ocol;
    if (s1_hund != 4'd0) begin
      q_job.ndig      = 2'd3;
      q_job.digits[0] = s1_hund;
      q_job.digits[1] = tens;
      q_job.digits[2] = ones;
    end else if (tens != 4'd0) begin
      q_job.ndig      = 2'd2;
      q_job.digits[0] = tens;
      q_job.digits[1] = ones;
    end else begin
      q_job.ndig      = 2'd1;
      q_job.digits[0] = ones;
    end
  end

  assign q_push = s1_valid;

endmodule

[rtl/core/dngr_queue.sv]
// ----------------------------------------------------------------------------
// dngr_queue
// Short job queue between the front and the pixel back end.
// ----------------------------------------------------------------------------
module dngr_queue import dngr_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop,
  output job_t pop_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_job    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

[rtl/core/dngr_back.sv]
// ----------------------------------------------------------------------------
// dngr_back
// Walks the 5 by 11 box of one job and emits one colored pixel per cycle,
// while out_ready does not stall it, through a registered output.
// ----------------------------------------------------------------------------
module dngr_back import dngr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  job_t      q_job,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic [2:0] r_cnt;
  logic [3:0] c_cnt;

  logic        load;
  logic        at_last;
  logic [1:0]  slot;
  logic [1:0]  sub;
  logic [3:0]  digit;
  logic [14:0] gbits;
  logic [2:0]  grow;
  logic        in_cell;
  logic [15:0] color;

  assign load    = q_valid && (!out_valid || out_ready);
  assign at_last = (r_cnt == LAST_ROW) && (c_cnt == LAST_COL);
  assign q_pop   = load && at_last;

  assign slot = c_cnt[3:2];
  assign sub  = c_cnt[1:0];

  always_comb begin
    unique case (slot)
      2'd0:    digit = q_job.digits[0];
      2'd1:    digit = q_job.digits[1];
      2'd2:    digit = q_job.digits[2];
      default: digit = 4'd0;
    endcase
  end

  assign gbits = glyph(digit);

  always_comb begin
    unique case (r_cnt)
      3'd0:    grow = gbits[2:0];
      3'd1:    grow = gbits[5:3];
      3'd2:    grow = gbits[8:6];
      3'd3:    grow = gbits[11:9];
      3'd4:    grow = gbits[14:12];
      default: grow = 3'd0;
    endcase
  end

  assign in_cell = (sub != GAP_SUB) && (slot < q_job.ndig);

  always_comb begin
    if (!in_cell) begin
      color = cfg.clear;
    end else if (grow[sub]) begin
      color = cfg.ink;
    end else begin
      color = cfg.paper;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_cnt     <= '0;
      c_cnt     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        if (c_cnt == LAST_COL) begin
          c_cnt <= '0;
          r_cnt <= at_last ? '0 : r_cnt + 1'b1;
        end else begin
          c_cnt <= c_cnt + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item.pixel_row   <= q_job.orow + 8'(r_cnt);
      out_item.pixel_col   <= q_job.ocol + 9'(c_cnt);
      out_item.pixel_color <= color;
      out_item.last_pixel  <= at_last;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (r_cnt <= LAST_ROW) && (c_cnt <= LAST_COL))
    else $error("pixel counter out of range");

  a_last_rewinds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.last_pixel) |-> (r_cnt == '0 && c_cnt == '0))
    else $error("counters not rewound after last pixel");

  a_mid_box: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.last_pixel) |-> (r_cnt != '0 || c_cnt != '0))
    else $error("counters rewound before last pixel");

endmodule

[rtl/core/decimal_number_glyph_renderer.sv]
// ----------------------------------------------------------------------------
// decimal_number_glyph_renderer
// Draws a number from 0 to 999 as up to three 3x5 digit glyphs into a
// 5 by 11 pixel box and emits the 55 box pixels in row-major order.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_item   (value, origin)
//   out      output     out_valid / out_ready  out_item  (pixel, color, last)
//   cfg      input      cfg_wr_en              cfg_index, cfg_data
//
// Pixels come one per cycle from the box walk counter in the back end while
// out_ready does not stall it; a job passes the front stage register and
// the job queue before its first pixel.
// A two-entry job queue lets the front take the next item while a box is still
// drawn; out_ready low stalls the back end, and the front once the queue is full.
// Reset clears the pipeline and the queue and sets the colors to their
// defaults: ink 0x0000, paper and clear 0xFFFF.
// ----------------------------------------------------------------------------
module decimal_number_glyph_renderer import dngr_pkg::*; #(
  parameter int SCREEN_HEIGHT = 240,
  parameter int SCREEN_WIDTH  = 320
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg;
  logic q_push;
  logic q_ready;
  job_t q_in_job;
  logic q_valid;
  logic q_pop;
  job_t q_out_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ink   <= INK_RESET;
      cfg.paper <= PAPER_RESET;
      cfg.clear <= CLEAR_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_INK:   cfg.ink   <= cfg_data;
        REG_PAPER: cfg.paper <= cfg_data;
        REG_CLEAR: cfg.clear <= cfg_data;
        default: ;
      endcase
    end
  end

  dngr_front #(
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item (in_item),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_job   (q_in_job)
  );

  dngr_queue #(
    .DEPTH(2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_ready(q_ready),
    .push_job  (q_in_job),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_job   (q_out_job)
  );

  dngr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_job    (q_out_job),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

[test/tb_decimal_number_glyph_renderer.sv]
// ----------------------------------------------------------------------------
// tb_decimal_number_glyph_renderer
// Self-checking bench for the decimal number glyph renderer.
// Numbers with a screen origin go in, and every one of the 55 pixel items of
// the box is predicted and compared in order against the block's output.
// Corner numbers and origins come first. Random numbers follow, under
// several color settings, with random gaps on the input and random stalls
// on the output in all but one of the settings.
// ----------------------------------------------------------------------------
module tb_decimal_number_glyph_renderer;
  import dngr_pkg::*;

  localparam int ROW_LIMIT    = 240 - 5;
  localparam int COL_LIMIT    = 320 - 11;
  localparam int DRAIN_CYCLES = 16;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  // glyph rows top to bottom, bit c of a row is column c
  localparam logic [0:9][14:0] FONT = {
    {3'd7, 3'd5, 3'd5, 3'd5, 3'd7},
    {3'd2, 3'd3, 3'd2, 3'd2, 3'd7},
    {3'd7, 3'd4, 3'd7, 3'd1, 3'd7},
    {3'd7, 3'd4, 3'd7, 3'd4, 3'd7},
    {3'd5, 3'd5, 3'd7, 3'd4, 3'd4},
    {3'd7, 3'd1, 3'd7, 3'd4, 3'd7},
    {3'd7, 3'd1, 3'd7, 3'd5, 3'd7},
    {3'd7, 3'd4, 3'd4, 3'd4, 3'd4},
    {3'd7, 3'd5, 3'd7, 3'd5, 3'd7},
    {3'd7, 3'd5, 3'd7, 3'd4, 3'd7}
  };

  class pixel_board;
    out_item_t   pending_pixels[$];
    logic [15:0] ink_color;
    logic [15:0] paper_color;
    logic [15:0] clear_color;
    int unsigned mismatches;

    function new();
      ink_color   = 16'h0000;
      paper_color = 16'hFFFF;
      clear_color = 16'hFFFF;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_INK:   ink_color   = data;
        REG_PAPER: paper_color = data;
        REG_CLEAR: clear_color = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return pending_pixels.size();
    endfunction

    function void note_number(in_item_t it);
      int unsigned num, orow, ocol, ndig, slot, sub;
      int unsigned dig[3];
      logic [14:0] shape;
      logic [2:0]  row_bits;
      out_item_t   px;
      num  = it.value;
      orow = it.origin_row;
      ocol = it.origin_col;
      if (num > 999) num = 999;
      if (orow > ROW_LIMIT) orow = ROW_LIMIT;
      if (ocol > COL_LIMIT) ocol = COL_LIMIT;
      if (num >= 100) begin
        ndig = 3;
        dig[0] = num / 100;
        dig[1] = (num / 10) % 10;
        dig[2] = num % 10;
      end else if (num >= 10) begin
        ndig = 2;
        dig[0] = num / 10;
        dig[1] = num % 10;
        dig[2] = 0;
      end else begin
        ndig = 1;
        dig[0] = num;
        dig[1] = 0;
        dig[2] = 0;
      end
      for (int r = 0; r < 5; r++) begin
        for (int c = 0; c < 11; c++) begin
          slot = c / 4;
          sub  = c % 4;
          px.pixel_color = clear_color;
          if (sub < 3 && slot < ndig) begin
            shape    = FONT[dig[slot]];
            row_bits = shape[14 - 3 * r -: 3];
            px.pixel_color = row_bits[sub] ? ink_color : paper_color;
          end
          px.pixel_row  = 8'(orow + r);
          px.pixel_col  = 9'(ocol + c);
          px.last_pixel = (r == 4 && c == 10);
          pending_pixels.push_back(px);
        end
      end
    endfunction

    function void report(string field, logic [15:0] want, logic [15:0] got);
      mismatches++;
      $display("%0t %s expected %h actual %h", $time, field, want, got);
    endfunction

    function void check_pixel(out_item_t got);
      out_item_t want;
      if (pending_pixels.size() == 0) begin
        report("unexpected item, pixel_color", 16'h0, got.pixel_color);
        return;
      end
      want = pending_pixels.pop_front();
      if (got.pixel_row != want.pixel_row)
        report("pixel_row", 16'(want.pixel_row), 16'(got.pixel_row));
      if (got.pixel_col != want.pixel_col)
        report("pixel_col", 16'(want.pixel_col), 16'(got.pixel_col));
      if (got.pixel_color != want.pixel_color)
        report("pixel_color", want.pixel_color, got.pixel_color);
      if (got.last_pixel != want.last_pixel)
        report("last_pixel", 16'(want.last_pixel), 16'(got.last_pixel));
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic        tx_free = 1'b0;
  logic        rx_free = 1'b0;
  int unsigned hold_left = 0;

  pixel_board board = new();

  decimal_number_glyph_renderer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  function automatic in_item_t random_number();
    in_item_t it;
    case ($urandom_range(0, 7))
      0, 1:    it.value = 10'($urandom_range(0, 9));
      2, 3:    it.value = 10'($urandom_range(10, 99));
      4:       it.value = 10'($urandom_range(1000, 1023));
      default: it.value = 10'($urandom_range(0, 1023));
    endcase
    it.origin_row = 8'($urandom_range(0, 255));
    it.origin_col = 9'($urandom_range(0, 511));
    return it;
  endfunction

  // output side: random stalls, none while rx_free is set
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_pixel(out_item);
    if (rx_free) begin
      out_ready <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ($urandom_range(0, 2) != 0) begin
      out_ready <= 1'b1;
      hold_left <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b0;
      hold_left <= pick_gap();
    end
  end

  task automatic send_number(input in_item_t it);
    int unsigned gap;
    gap = tx_free ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    board.note_number(it);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    board.write_reg(idx, data);
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    in_item_t corners [15];
    corners = '{
      '{10'd0,    8'd0,   9'd0},
      '{10'd7,    8'd235, 9'd309},
      '{10'd9,    8'd236, 9'd310},
      '{10'd10,   8'd255, 9'd511},
      '{10'd99,   8'd1,   9'd1},
      '{10'd100,  8'd100, 9'd200},
      '{10'd123,  8'd17,  9'd300},
      '{10'd456,  8'd234, 9'd308},
      '{10'd789,  8'd128, 9'd256},
      '{10'd999,  8'd64,  9'd31},
      '{10'd1000, 8'd200, 9'd100},
      '{10'd1023, 8'd255, 9'd511},
      '{10'd512,  8'd170, 9'd341},
      '{10'd300,  8'd85,  9'd170},
      '{10'd5,    8'd120, 9'd160}
    };
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (corners[i]) send_number(corners[i]);

    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin
          write_reg(REG_INK, 16'hFFFF);
          write_reg(REG_PAPER, 16'h0000);
          write_reg(REG_CLEAR, 16'h0000);
        end
        1: begin
          write_reg(REG_INK, 16'($urandom));
          write_reg(REG_PAPER, 16'($urandom));
          write_reg(REG_CLEAR, 16'($urandom));
        end
        2: begin
          write_reg(REG_UNUSED, 16'($urandom));
          write_reg(REG_INK, 16'h0000);
          write_reg(REG_PAPER, 16'($urandom));
        end
        default: begin
          write_reg(REG_CLEAR, 16'hFFFF);
          write_reg(REG_INK, 16'($urandom));
          write_reg(REG_PAPER, 16'hFFFF);
          write_reg(REG_UNUSED, 16'hFFFF);
        end
      endcase
      end_writes();
      tx_free <= (phase == 1);
      rx_free <= (phase == 1);
      repeat (22) send_number(random_number());
    end

    settle();
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[decimal_number_glyph_renderer.f]
rtl/core/dngr_pkg.sv
rtl/core/dngr_front.sv
rtl/core/dngr_queue.sv
rtl/core/dngr_back.sv
rtl/core/decimal_number_glyph_renderer.sv
test/tb_decimal_number_glyph_renderer.sv
